### hdl/cpgma_pkg.sv
// Shared types, constants and functions for the CpG context methylation block.
// Used by cpgma_ctx, cpgma_rsp_queue and cpg_context_methylation_assign_core.
// No dependencies.
package cpgma_pkg;

   localparam int PCT_W        = 7;
   localparam int BASE_W       = 8;
   localparam int CSR_ADDR_W   = 2;
   localparam int RSP_DEPTH_DEF = 4;

   localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

   localparam logic [PCT_W-1:0] CPG_PCT_RST    = 7'd90;
   localparam logic [PCT_W-1:0] NONCPG_PCT_RST = 7'd1;
   localparam logic [PCT_W-1:0] ISLAND_PCT_RST = 7'd10;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_CPG_PCT    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_NONCPG_PCT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ISLAND_PCT = 2'd2;

   // ASCII codes of the two nucleotides that matter.
   localparam logic [BASE_W-1:0] CHAR_C_UP = 8'h43;
   localparam logic [BASE_W-1:0] CHAR_C_LO = 8'h63;
   localparam logic [BASE_W-1:0] CHAR_G_UP = 8'h47;
   localparam logic [BASE_W-1:0] CHAR_G_LO = 8'h67;

   // Base class codes.
   localparam logic [1:0] CLS_OTHER = 2'd0;
   localparam logic [1:0] CLS_C     = 2'd1;
   localparam logic [1:0] CLS_G     = 2'd2;

   typedef struct packed {
      logic [PCT_W-1:0] cpg;
      logic [PCT_W-1:0] noncpg;
      logic [PCT_W-1:0] island;
   } pct_set_type;

   typedef struct packed {
      logic             is_last;
      logic [PCT_W-1:0] ratio_percent;
   } rsp_entry_type;

   // Up to two results produced by one accepted request, first in order first.
   typedef struct packed {
      logic [1:0]    num;
      rsp_entry_type first;
      rsp_entry_type second;
   } push_type;

   function automatic logic [1:0] classify(input logic [BASE_W-1:0] b);
      logic [1:0] cls;
      case (b) inside
         CHAR_C_UP, CHAR_C_LO: cls = CLS_C;
         CHAR_G_UP, CHAR_G_LO: cls = CLS_G;
         default:              cls = CLS_OTHER;
      endcase
      return cls;
   endfunction

   function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] p);
      return (p > PCT_MAX) ? PCT_MAX : p;
   endfunction

   // Percent for one base; the percent set is already saturated.
   function automatic logic [PCT_W-1:0] percent_for(input logic [1:0]  cls,
                                                    input logic        cpg_ctx,
                                                    input logic        isl,
                                                    input pct_set_type pct);
      logic [PCT_W-1:0] r;
      if (cls != CLS_C && cls != CLS_G) begin
         r = '0;
      end else if (!cpg_ctx) begin
         r = pct.noncpg;
      end else if (isl) begin
         r = pct.island;
      end else begin
         r = pct.cpg;
      end
      return r;
   endfunction

endpackage

### hdl/cpgma_ctx.sv
// One-base lookahead stage: holds the previous base and decides its CpG context.
// Depends on cpgma_pkg.
module cpgma_ctx (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [cpgma_pkg::BASE_W-1:0]    base,
   input  logic                            chrom_start,
   input  logic                            in_island,
   input  logic                            last,
   input  cpgma_pkg::pct_set_type          pct,
   output cpgma_pkg::push_type             push
);
   import cpgma_pkg::*;

   logic [1:0] held_class_ff, held_class_in;
   logic       held_island_ff, held_island_in;
   logic       held_after_c_ff, held_after_c_in;
   logic       held_valid_ff, held_valid_in;

   logic [1:0]    cls;
   logic          held_ctx;
   logic          after_c;
   rsp_entry_type held_rsp;
   rsp_entry_type cur_rsp;

   always_comb begin
      cls     = classify(base);
      after_c = held_valid_ff && !chrom_start && (held_class_ff == CLS_C);

      case (held_class_ff)
         CLS_C:   held_ctx = !chrom_start && (cls == CLS_G);
         CLS_G:   held_ctx = held_after_c_ff;
         default: held_ctx = 1'b0;
      endcase

      held_rsp.ratio_percent = percent_for(held_class_ff, held_ctx, held_island_ff, pct);
      held_rsp.is_last       = 1'b0;
      cur_rsp.ratio_percent  = percent_for(cls, (cls == CLS_G) && after_c, in_island, pct);
      cur_rsp.is_last        = 1'b1;

      // Results are packed so the first pushed entry is always the older one.
      push.num    = accept ? ({1'b0, held_valid_ff} + {1'b0, last}) : 2'd0;
      push.first  = held_valid_ff ? held_rsp : cur_rsp;
      push.second = cur_rsp;

      held_class_in   = held_class_ff;
      held_island_in  = held_island_ff;
      held_after_c_in = held_after_c_ff;
      held_valid_in   = held_valid_ff;
      if (accept) begin
         if (last) begin
            held_class_in   = CLS_OTHER;
            held_island_in  = 1'b0;
            held_after_c_in = 1'b0;
            held_valid_in   = 1'b0;
         end else begin
            held_class_in   = cls;
            held_island_in  = in_island;
            held_after_c_in = after_c;
            held_valid_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_class_ff   <= CLS_OTHER;
         held_island_ff  <= 1'b0;
         held_after_c_ff <= 1'b0;
         held_valid_ff   <= 1'b0;
      end else begin
         held_class_ff   <= held_class_in;
         held_island_ff  <= held_island_in;
         held_after_c_ff <= held_after_c_in;
         held_valid_ff   <= held_valid_in;
      end
   end

endmodule

### hdl/cpgma_rsp_queue.sv
// Small response queue: takes up to two entries per cycle, hands out one.
// Depends on cpgma_pkg.
module cpgma_rsp_queue #(
   parameter int DEPTH = cpgma_pkg::RSP_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cpgma_pkg::push_type            push,
   input  logic                           pop,
   output cpgma_pkg::rsp_entry_type       head,
   output logic [$clog2(DEPTH+1)-1:0]     count
);
   import cpgma_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH-1);

   rsp_entry_type    slot_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] wr_ptr_nxt;
   logic [IDX_W-1:0] wr_ptr_nxt2;

   function automatic logic [IDX_W-1:0] inc_ptr(input logic [IDX_W-1:0] p);
      return (p == IDX_LAST) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_nxt  = inc_ptr(wr_ptr_ff);
      wr_ptr_nxt2 = inc_ptr(wr_ptr_nxt);
      case (push.num)
         2'd1:    wr_ptr_in = wr_ptr_nxt;
         2'd2:    wr_ptr_in = wr_ptr_nxt2;
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? inc_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.num) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         slot_ff[wr_ptr_nxt] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head  = slot_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

### hdl/cpg_context_methylation_assign_core.sv
// CpG context methylation classifier, top level.
// A base's result is known when the next base (or its own last flag) is accepted; it
// then enters the response queue and is offered on rsp_ behind any earlier results.
// One request per cycle while the queue has room; a last request pushes up to two results.
// Reset (synchronous, active high) empties the queue, drops the held base and reloads the
// percent registers with 90 / 1 / 10.
// Depends on cpgma_pkg, cpgma_ctx and cpgma_rsp_queue.
module cpg_context_methylation_assign_core #(
   parameter int RSP_DEPTH = cpgma_pkg::RSP_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] base
   input  logic [1:0]                        req_tuser,   // [0] chrom_start, [1] in_island
   input  logic                              req_tlast,   // last base of the genome
   // Result channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [6:0] ratio_percent, [7] zero
   output logic                              rsp_tlast,   // is_last
   // Configuration write port.
   input  logic                              csr_we,
   input  logic [cpgma_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [cpgma_pkg::PCT_W-1:0]       csr_wdata
);
   import cpgma_pkg::*;

   localparam int CNT_W = $clog2(RSP_DEPTH+1);

   // Percent registers; the user must write them only while the block is idle (not enforced).
   logic [PCT_W-1:0] cpg_pct_ff, cpg_pct_in;
   logic [PCT_W-1:0] noncpg_pct_ff, noncpg_pct_in;
   logic [PCT_W-1:0] island_pct_ff, island_pct_in;

   pct_set_type      pct;
   push_type         push;
   rsp_entry_type    head;
   logic [CNT_W-1:0] q_count;
   logic             req_accept;
   logic             rsp_accept;

   always_comb begin
      cpg_pct_in    = cpg_pct_ff;
      noncpg_pct_in = noncpg_pct_ff;
      island_pct_in = island_pct_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_CPG_PCT:    cpg_pct_in    = csr_wdata;
            CSR_NONCPG_PCT: noncpg_pct_in = csr_wdata;
            CSR_ISLAND_PCT: island_pct_in = csr_wdata;
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpg_pct_ff    <= CPG_PCT_RST;
         noncpg_pct_ff <= NONCPG_PCT_RST;
         island_pct_ff <= ISLAND_PCT_RST;
      end else begin
         cpg_pct_ff    <= cpg_pct_in;
         noncpg_pct_ff <= noncpg_pct_in;
         island_pct_ff <= island_pct_in;
      end
   end

   // Values above 100 are clamped where they are used.
   assign pct.cpg    = sat_pct(cpg_pct_ff);
   assign pct.noncpg = sat_pct(noncpg_pct_ff);
   assign pct.island = sat_pct(island_pct_ff);

   // A request may push two results, so the queue must have two free slots to take one.
   // Results drain in the same cycle, so one request per cycle holds while rsp_tready is high.
   assign req_tready = (q_count <= CNT_W'(RSP_DEPTH-2));
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   cpgma_ctx u_ctx (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .base        (req_tdata),
      .chrom_start (req_tuser[0]),
      .in_island   (req_tuser[1]),
      .last        (req_tlast),
      .pct         (pct),
      .push        (push)
   );

   cpgma_rsp_queue #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (rsp_accept),
      .head  (head),
      .count (q_count)
   );

   assign rsp_tvalid = (q_count != '0);
   assign rsp_tdata  = {1'b0, head.ratio_percent};
   assign rsp_tlast  = head.is_last;

   // The queue never holds more entries than it has slots.
   assert property (@(posedge clock) disable iff (reset) q_count <= CNT_W'(RSP_DEPTH))
      else $error("response queue overfilled");

   // A last request always leaves at least one result waiting.
   assert property (@(posedge clock) disable iff (reset)
                    (req_accept && req_tlast) |=> rsp_tvalid)
      else $error("last request produced no result");

   // Without a request, the count can only stay or drop by one as results leave.
   assert property (@(posedge clock) disable iff (reset)
                    !req_accept |=> (q_count == $past(q_count) - CNT_W'($past(rsp_accept))))
      else $error("queue count changed without a request");

   // A pushed pair always ends with the last-flagged result.
   assert property (@(posedge clock) disable iff (reset)
                    (push.num == 2'd2) |-> (req_tlast && push.second.is_last))
      else $error("two results pushed without a last request");

endmodule

### tb/cpgma_pct_checker.sv
`timescale 1ns / 1ps
// Result checker for the CpG context methylation block: watches the request,
// result and register-write channels, predicts each percent and compares it.
// Depends on cpgma_pkg for the register indexes, base codes and reset values.
module cpgma_pct_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] base
   input  logic [1:0]                       req_tuser,   // [0] chrom_start, [1] in_island
   input  logic                             req_tlast,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [7:0]                       rsp_tdata,   // [6:0] ratio_percent, [7] zero
   input  logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [cpgma_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [cpgma_pkg::PCT_W-1:0]      csr_wdata,
   input  logic                             check_leftover,
   output int                               mismatches,
   output int                               owed,
   output int                               compared
);
   import cpgma_pkg::*;

   rsp_entry_type owed_results[$];

   logic [PCT_W-1:0] cpg_pct, noncpg_pct, island_pct;
   logic [1:0]       prev_kind;
   logic             prev_island, prev_after_c, prev_owed;
   logic             leftover_done;

   initial begin
      mismatches    = 0;
      compared      = 0;
      owed          = 0;
      leftover_done = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
   endtask

   // Appends one expected result behind the ones already waiting.
   function automatic void owe_result(input rsp_entry_type r);
      owed_results.insert(owed_results.size(), r);
   endfunction

   function automatic logic [1:0] base_kind(input logic [7:0] b);
      if (b == CHAR_C_UP || b == CHAR_C_LO) return CLS_C;
      if (b == CHAR_G_UP || b == CHAR_G_LO) return CLS_G;
      return CLS_OTHER;
   endfunction

   function automatic logic [PCT_W-1:0] cap_pct(input logic [PCT_W-1:0] p);
      return (p > PCT_MAX) ? PCT_MAX : p;
   endfunction

   function automatic logic [PCT_W-1:0] methyl_pct(input logic [1:0] kind, input logic ctx,
                                                   input logic isl);
      if (kind != CLS_C && kind != CLS_G) return '0;
      if (!ctx) return cap_pct(noncpg_pct);
      return isl ? cap_pct(island_pct) : cap_pct(cpg_pct);
   endfunction

   always @(posedge clock) begin : watch
      rsp_entry_type want;
      logic [1:0]    kind;
      logic          start, isl, ctx, follows_c;
      if (reset) begin
         owed_results.delete();
         cpg_pct      = CPG_PCT_RST;
         noncpg_pct   = NONCPG_PCT_RST;
         island_pct   = ISLAND_PCT_RST;
         prev_kind    = CLS_OTHER;
         prev_island  = 1'b0;
         prev_after_c = 1'b0;
         prev_owed    = 1'b0;
      end else begin
         // Results first: a request taken at this edge cannot have produced one yet.
         if (rsp_tvalid && rsp_tready) begin
            if (owed_results.size() == 0) begin
               report_mismatch($sformatf("result %0d/%0b with nothing expected",
                                         rsp_tdata[6:0], rsp_tlast));
            end else begin
               want = owed_results.pop_front();
               compared++;
               if (rsp_tdata[6:0] !== want.ratio_percent)
                  report_mismatch($sformatf("ratio_percent %0d, expected %0d",
                                            rsp_tdata[6:0], want.ratio_percent));
               if (rsp_tdata[7] !== 1'b0)
                  report_mismatch("padding bit of rsp_tdata is not zero");
               if (rsp_tlast !== want.is_last)
                  report_mismatch($sformatf("is_last %0b, expected %0b",
                                            rsp_tlast, want.is_last));
            end
         end

         if (req_tvalid && req_tready) begin
            kind  = base_kind(req_tdata);
            start = req_tuser[0];
            isl   = req_tuser[1];
            // The held base is settled now that its successor is known.
            if (prev_owed) begin
               case (prev_kind)
                  CLS_C:   ctx = !start && kind == CLS_G;
                  CLS_G:   ctx = prev_after_c;
                  default: ctx = 1'b0;
               endcase
               want.ratio_percent = methyl_pct(prev_kind, ctx, prev_island);
               want.is_last       = 1'b0;
               owe_result(want);
            end
            follows_c = prev_owed && !start && prev_kind == CLS_C;
            if (req_tlast) begin
               want.ratio_percent = methyl_pct(kind, kind == CLS_G && follows_c, isl);
               want.is_last       = 1'b1;
               owe_result(want);
               prev_kind    = CLS_OTHER;
               prev_island  = 1'b0;
               prev_after_c = 1'b0;
               prev_owed    = 1'b0;
            end else begin
               prev_kind    = kind;
               prev_island  = isl;
               prev_after_c = follows_c;
               prev_owed    = 1'b1;
            end
         end

         if (csr_we) begin
            case (csr_addr)
               CSR_CPG_PCT:    cpg_pct    = csr_wdata;
               CSR_NONCPG_PCT: noncpg_pct = csr_wdata;
               CSR_ISLAND_PCT: island_pct = csr_wdata;
               default: ;
            endcase
         end

         if (check_leftover && !leftover_done) begin
            leftover_done = 1'b1;
            foreach (owed_results[i])
               report_mismatch($sformatf("result %0d/%0b never arrived",
                                         owed_results[i].ratio_percent,
                                         owed_results[i].is_last));
         end
      end
      owed <= owed_results.size();
   end

endmodule

### tb/tb_cpg_context_methylation_assign_core.sv
`timescale 1ns / 1ps
// Top of the testbench for cpg_context_methylation_assign_core: clock, reset, base
// stream, register writes and the verdict. Needs cpgma_pkg and cpgma_pct_checker.
module tb_cpg_context_methylation_assign_core;
   import cpgma_pkg::*;

   // Longest run of cycles with no transfer on either channel before the run is
   // declared hung. Receiver stalls, also when they chain back to back, stay far
   // below this limit, as do the register-write pauses.
   localparam int STALL_LIMIT   = 2000;
   // Cycles to let pass after the last result before touching the registers.
   localparam int SETTLE_CYCLES = 4;
   localparam int NUM_PHASES    = 6;
   // Whole genomes overrun each phase's share a little, so the total lands near 950.
   localparam int RANDOM_ITEMS  = 840;
   // Index that maps to no register; writes to it must change nothing.
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [PCT_W-1:0]      csr_wdata  = '0;
   logic                  check_leftover = 1'b0;

   int mismatches, owed, compared;
   int sent          = 0;
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   int rsp_hold      = 0;
   int idle_cycles   = 0;

   cpg_context_methylation_assign_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   cpgma_pct_checker pct_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .check_leftover (check_leftover),
      .mismatches     (mismatches),
      .owed           (owed),
      .compared       (compared)
   );

   always #5 clock = ~clock;

   // Picks the length of an idle stretch; one pick in twenty comes from the long range.
   function automatic int pick_gap();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   // A base byte biased toward DNA letters of both cases. After a C, a G is likely,
   // so that CpG pairs are common. A few bytes are arbitrary noise.
   function automatic logic [7:0] pick_base(input logic prev_c);
      int r;
      r = $urandom_range(0, 99);
      if (prev_c && r < 50) return $urandom_range(0, 1) ? CHAR_G_UP : CHAR_G_LO;
      r = $urandom_range(0, 99);
      if (r < 8)  return 8'($urandom_range(0, 255));
      if (r < 33) return $urandom_range(0, 1) ? CHAR_C_UP : CHAR_C_LO;
      if (r < 58) return $urandom_range(0, 1) ? CHAR_G_UP : CHAR_G_LO;
      case ($urandom_range(0, 4))
         0:       return "A";
         1:       return "T";
         2:       return "a";
         3:       return "t";
         default: return "N";
      endcase
   endfunction

   // The receiver drops rsp_tready for random stretches; with a zero stall
   // percentage it stays ready every cycle.
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_hold   <= pick_gap() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // The watchdog restarts on every transfer, so it only fires on a real hang.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one request and holds it until it is taken. Always entered right
   // after a rising edge. With some probability the sender then goes idle.
   task automatic send_request(input logic [7:0] base, input logic chrom_start,
                               input logic in_island, input logic last);
      req_tdata  <= base;
      req_tuser  <= {in_island, chrom_start};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      if ($urandom_range(0, 99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   // Stops the sender until every expected result has come back, then lets the settle
   // time pass so the block can finish any work that has no result of its own.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [PCT_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Loads the percent registers and idle rates for one phase. The block is idle
   // when this runs: the previous stream ended with a last base and drained.
   task automatic apply_setting(input int phase);
      case (phase)
         0: begin
            write_reg(CSR_CPG_PCT, CPG_PCT_RST);
            write_reg(CSR_NONCPG_PCT, NONCPG_PCT_RST);
            write_reg(CSR_ISLAND_PCT, ISLAND_PCT_RST);
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end
         1: begin
            write_reg(CSR_CPG_PCT, 7'd0);
            write_reg(CSR_NONCPG_PCT, 7'd0);
            write_reg(CSR_ISLAND_PCT, 7'd0);
            req_gap_pct   = 20;
            rsp_stall_pct = 20;
         end
         2: begin
            write_reg(CSR_CPG_PCT, 7'd100);
            write_reg(CSR_NONCPG_PCT, 7'd100);
            write_reg(CSR_ISLAND_PCT, 7'd100);
            req_gap_pct   = 40;
            rsp_stall_pct = 30;
         end
         3: begin
            // Values above 100 must be clamped to 100 when they are used.
            write_reg(CSR_CPG_PCT, 7'd127);
            write_reg(CSR_NONCPG_PCT, 7'd101);
            write_reg(CSR_ISLAND_PCT, 7'd115);
            write_reg(CSR_SPARE, 7'd55);
            req_gap_pct   = 25;
            rsp_stall_pct = 60;
         end
         4: begin
            write_reg(CSR_CPG_PCT, 7'($urandom_range(0, 127)));
            write_reg(CSR_NONCPG_PCT, 7'($urandom_range(0, 127)));
            write_reg(CSR_ISLAND_PCT, 7'($urandom_range(0, 127)));
            req_gap_pct   = 50;
            rsp_stall_pct = 50;
         end
         default: begin
            write_reg(CSR_CPG_PCT, 7'd45);
            write_reg(CSR_NONCPG_PCT, 7'd7);
            write_reg(CSR_ISLAND_PCT, 7'd100);
            req_gap_pct   = 10;
            rsp_stall_pct = 10;
         end
      endcase
      csr_we <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int         target, glen;
      logic [7:0] b;
      logic       island, start, prev_c, hold_done;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, run on the reset values 90 / 1 / 10 with light idling.
      req_gap_pct   = 15;
      rsp_stall_pct = 15;
      // The very first base has no previous base even without chrom_start.
      send_request(CHAR_C_UP, 1'b0, 1'b0, 1'b0);
      send_request(CHAR_G_UP, 1'b0, 1'b0, 1'b0);
      // A CpG pair inside an island, lower case.
      send_request(CHAR_C_LO, 1'b0, 1'b1, 1'b0);
      send_request(CHAR_G_LO, 1'b0, 1'b1, 1'b0);
      // The C is in an island and its G is not: each keeps its own island flag.
      send_request(CHAR_C_UP, 1'b0, 1'b1, 1'b0);
      send_request(CHAR_G_UP, 1'b0, 1'b0, 1'b0);
      // A chromosome boundary splits the pair: both are non-CpG.
      send_request(CHAR_C_UP, 1'b0, 1'b0, 1'b0);
      send_request(CHAR_G_UP, 1'b1, 1'b0, 1'b0);
      // Bases that are neither C nor G, including the byte extremes.
      send_request("A", 1'b0, 1'b0, 1'b0);
      send_request("t", 1'b0, 1'b1, 1'b0);
      send_request("N", 1'b1, 1'b0, 1'b0);
      send_request(8'hFF, 1'b0, 1'b1, 1'b0);
      send_request(8'h00, 1'b0, 1'b0, 1'b0);
      send_request(CHAR_G_UP, 1'b0, 1'b0, 1'b0);
      // Mixed case pairs, with a C chain before the G.
      send_request(CHAR_G_LO, 1'b1, 1'b1, 1'b0);
      send_request(CHAR_C_LO, 1'b0, 1'b1, 1'b0);
      send_request(CHAR_C_UP, 1'b0, 1'b0, 1'b0);
      send_request(CHAR_G_LO, 1'b0, 1'b0, 1'b0);
      // The final base is a C with nothing after it: two results at once.
      send_request(CHAR_C_UP, 1'b0, 1'b0, 1'b1);
      // A fresh stream whose only base is also the last: a single result, and the
      // G has no previous base.
      send_request(CHAR_G_UP, 1'b0, 1'b0, 1'b1);
      send_request(CHAR_C_UP, 1'b1, 1'b1, 1'b0);
      send_request(CHAR_G_LO, 1'b0, 1'b1, 1'b1);
      send_request(8'h80, 1'b0, 1'b1, 1'b1);
      settle();

      // Random part: whole genomes of random length, each ending with a last base,
      // under several register settings. Once per phase the sender stops with a
      // base held until every result has come back.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         apply_setting(phase);
         target    = sent + RANDOM_ITEMS / NUM_PHASES;
         hold_done = 1'b0;
         while (sent < target) begin
            glen   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 20);
            island = 1'($urandom_range(0, 1));
            prev_c = 1'b0;
            for (int i = 0; i < glen; i++) begin
               b = pick_base(prev_c);
               // Most genomes open with chrom_start; a few do not. Inside a
               // genome an occasional base starts a new chromosome.
               start = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 24) == 0);
               if ($urandom_range(0, 9) == 0) island = ~island;
               send_request(b, start, island, i == glen - 1);
               prev_c = (b == CHAR_C_UP || b == CHAR_C_LO);
               if (!hold_done && i == 0 && glen > 1) begin
                  hold_done = 1'b1;
                  settle();
               end
            end
         end
         settle();
      end

      // Drain with the receiver always ready, so that any stray extra result
      // shows up, then look for expectations that were never met.
      rsp_stall_pct = 0;
      settle();
      check_leftover <= 1'b1;
      repeat (2) @(posedge clock);

      $display("Run covered %0d base requests over %0d register settings plus directed cases.",
               sent, NUM_PHASES);
      $display("%0d results compared, %0d mismatches.", compared, mismatches);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
